### rtl/core/ara_pkg.sv
// Shared types, constants and helpers for the address range allocator.
`timescale 1ns / 1ps
package ara_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int IW = $clog2(MAX_SEGMENTS + 1);
    localparam int CW = $clog2(MAX_SEGMENTS);
    localparam int DIV_STEPS = 33;
    localparam int DW = $clog2(DIV_STEPS + 1);

    localparam logic [2:0] OP_ADD_FREE = 3'd0;
    localparam logic [2:0] OP_ALLOC_AT = 3'd1;
    localparam logic [2:0] OP_ALLOC_LOW = 3'd2;
    localparam logic [2:0] OP_ALLOC_HIGH = 3'd3;
    localparam logic [2:0] OP_ALLOC_BEST = 3'd4;
    localparam logic [2:0] OP_FREE = 3'd5;
    localparam logic [2:0] OP_FIND = 3'd6;

    localparam logic [2:0] STAT_OK = 3'd0;
    localparam logic [2:0] STAT_BAD_ARGUMENT = 3'd1;
    localparam logic [2:0] STAT_OUT_OF_BOUNDS = 3'd2;
    localparam logic [2:0] STAT_IN_USE = 3'd3;
    localparam logic [2:0] STAT_TOO_BIG = 3'd4;
    localparam logic [2:0] STAT_OUT_OF_MEMORY = 3'd5;
    localparam logic [2:0] STAT_OUT_OF_RESOURCES = 3'd6;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd7;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] size;
        logic        free;
    } seg_t;

    typedef enum logic [2:0] {
        CMD_HOLD   = 3'd0,
        CMD_ROT    = 3'd1,
        CMD_WRITE  = 3'd2,
        CMD_INSERT = 3'd3,
        CMD_REMOVE = 3'd4
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t       cmd;
        logic [IW-1:0]   idx;
        seg_t            data;
    } cell_ctl_t;

    function automatic cell_ctl_t mk_ctl(cell_cmd_t cmd, logic [IW-1:0] idx,
                                         logic [31:0] s, logic [31:0] z, logic f);
        cell_ctl_t c;
        c.cmd = cmd;
        c.idx = idx;
        c.data.start = s;
        c.data.size = z;
        c.data.free = f;
        return c;
    endfunction

endpackage

### rtl/core/address_range_allocator_top.sv
// Top level: segment table as a rotating chain of cells plus control sequencer.
// Each request rotates the full table through a scan pass and a gather pass; each free segment
// scanned as an aligned fit candidate also waits for the alignment division in the shared divider.
// Throughput: one transaction in flight; the next input is taken in the cycle after the result
// is loaded, while the previous result may still wait in the output register.
// Reset (synchronous, active low) empties the table; cell contents are not cleared.
`timescale 1ns / 1ps
module address_range_allocator_top import ara_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [31:0] s_address,
    input  logic [31:0] s_length,
    input  logic [31:0] s_alignment,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_seg_start,
    output logic [31:0] m_seg_size,
    output logic        m_seg_free
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_DIVW   = 7'b0000100,
        S_GATHER = 7'b0001000,
        S_DECIDE = 7'b0010000,
        S_MODIFY = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t        state_reg;
    logic [2:0]    op_reg;
    logic [31:0]   addr_reg, len_reg, al_reg, a_reg, bz_reg;
    logic [IW-1:0] cnt_reg, last_reg, g_reg;
    logic [CW-1:0] k_reg;
    logic          last_ok_reg, found_reg;
    seg_t          p_reg, c_reg, n_reg;
    logic          p_ok_reg, c_ok_reg, n_ok_reg;
    cell_ctl_t     prim_reg [3];
    logic [1:0]    nprim_reg, pi_reg;
    logic [2:0]    res_st_reg, m_status_reg;
    logic [31:0]   res_s_reg, res_z_reg, m_start_reg, m_size_reg;
    logic          res_f_reg, m_free_reg, m_valid_reg;

    seg_t      cell_q [MAX_SEGMENTS];
    cell_ctl_t ctl;
    seg_t      head;
    logic      hv, k_last, cand, advance, take;
    logic      div_done;
    logic [31:0] div_rem;
    logic [32:0] div_dvd, hi_v, hi_c;
    logic [33:0] lo_c;
    logic        fit;
    logic [31:0] fit_a;
    logic [IW-1:0] g_eff;
    logic [IW:0]   kk, ge;

    genvar i;
    generate
        for (i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
            seg_t lft, rgt;
            if (i == 0) begin : g_first
                assign lft = cell_q[0];
            end else begin : g_mid
                assign lft = cell_q[i-1];
            end
            if (i == MAX_SEGMENTS - 1) begin : g_last
                assign rgt = cell_q[0];
            end else begin : g_nlast
                assign rgt = cell_q[i+1];
            end
            ara_cell u_cell (
                .aclk(aclk), .cell_idx(IW'(i)), .ctl(ctl),
                .left_seg(lft), .right_seg(rgt), .q(cell_q[i])
            );
        end
    endgenerate

    assign head = cell_q[0];
    assign hv = IW'(k_reg) < cnt_reg;
    assign k_last = k_reg == CW'(MAX_SEGMENTS - 1);

    assign cand = (state_reg == S_SCAN) && hv && head.free && (head.size >= len_reg) &&
                  (op_reg == OP_ALLOC_LOW || op_reg == OP_ALLOC_HIGH ||
                   op_reg == OP_ALLOC_BEST) && len_reg != 32'd0 &&
                  !(op_reg == OP_ALLOC_LOW && found_reg);
    assign advance = ((state_reg == S_SCAN) && !cand) || ((state_reg == S_DIVW) && div_done);

    assign hi_v = {1'b0, head.start} + {1'b0, head.size} - {1'b0, len_reg};
    assign div_dvd = (op_reg == OP_ALLOC_HIGH) ? hi_v : {1'b0, head.start};

    ara_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cand), .dividend(div_dvd),
        .divisor(al_reg), .done(div_done), .rem(div_rem)
    );

    always_comb begin
        lo_c = {2'b0, head.start} + {2'b0, (div_rem == 32'd0) ? 32'd0 : al_reg - div_rem};
        hi_c = hi_v - {1'b0, div_rem};
        if (op_reg == OP_ALLOC_HIGH) begin
            fit = hi_c >= {1'b0, head.start};
            fit_a = hi_c[31:0];
        end else begin
            fit = (lo_c + {2'b0, len_reg}) <= ({2'b0, head.start} + {2'b0, head.size});
            fit_a = lo_c[31:0];
        end
        take = fit && (op_reg != OP_ALLOC_BEST || !found_reg || head.size < bz_reg);
    end

    always_comb begin
        case (op_reg)
            OP_ADD_FREE: g_eff = last_ok_reg ? last_reg + 1'b1 : '0;
            OP_ALLOC_AT, OP_FIND: g_eff = last_reg;
            default: g_eff = g_reg;
        endcase
        kk = {1'b0, IW'(k_reg)};
        ge = {1'b0, g_eff};
    end

    always_comb begin
        ctl = mk_ctl(CMD_HOLD, '0, 32'd0, 32'd0, 1'b0);
        if (advance || state_reg == S_GATHER) ctl.cmd = CMD_ROT;
        if (state_reg == S_MODIFY) ctl = prim_reg[pi_reg];
    end

    // decision from the gathered neighborhood
    logic [2:0]  d_st;
    logic [31:0] d_s, d_z;
    logic        d_f;
    cell_ctl_t   d_prim [3];
    logic [1:0]  d_n;
    logic        pa, na, pre, post, split;
    logic [31:0] sa, off;
    logic [32:0] end33;
    logic [1:0]  need;
    logic [IW-1:0] gb;

    always_comb begin
        d_st = STAT_OK;
        d_s = 32'd0;
        d_z = 32'd0;
        d_f = 1'b0;
        d_n = 2'd0;
        for (int j = 0; j < 3; j++) d_prim[j] = mk_ctl(CMD_HOLD, '0, 32'd0, 32'd0, 1'b0);
        pa = 1'b0;
        na = 1'b0;
        split = 1'b0;
        sa = a_reg;
        end33 = {1'b0, addr_reg} + {1'b0, len_reg};
        off = 32'd0;
        pre = 1'b0;
        post = 1'b0;
        need = 2'd0;
        gb = g_eff;
        case (op_reg)
            OP_ADD_FREE: begin
                pa = p_ok_reg && p_reg.free && (p_reg.start + p_reg.size == addr_reg);
                na = c_ok_reg && c_reg.free && (addr_reg + len_reg == c_reg.start);
                if (len_reg == 32'd0 || (end33[32] && end33[31:0] != 32'd0))
                    d_st = STAT_BAD_ARGUMENT;
                else if (p_ok_reg && (addr_reg - p_reg.start) < p_reg.size)
                    d_st = STAT_IN_USE;
                else if (c_ok_reg && (c_reg.start - addr_reg) < len_reg)
                    d_st = STAT_TOO_BIG;
                else if (cnt_reg >= IW'(MAX_SEGMENTS))
                    d_st = STAT_OUT_OF_RESOURCES;
                else begin
                    d_f = 1'b1;
                    d_s = pa ? p_reg.start : addr_reg;
                    d_z = len_reg + (pa ? p_reg.size : 32'd0) + (na ? c_reg.size : 32'd0);
                    d_n = 2'd1;
                    if (pa) begin
                        d_prim[0] = mk_ctl(CMD_WRITE, g_eff - 1'b1, d_s, d_z, 1'b1);
                        if (na) begin
                            d_prim[1] = mk_ctl(CMD_REMOVE, g_eff, d_s, d_z, 1'b1);
                            d_n = 2'd2;
                        end
                    end else if (na)
                        d_prim[0] = mk_ctl(CMD_WRITE, g_eff, d_s, d_z, 1'b1);
                    else
                        d_prim[0] = mk_ctl(CMD_INSERT, g_eff, d_s, d_z, 1'b1);
                end
            end
            OP_FREE: begin
                pa = p_ok_reg && p_reg.free && (p_reg.start + p_reg.size == c_reg.start);
                na = n_ok_reg && n_reg.free && (c_reg.start + c_reg.size == n_reg.start);
                if (!found_reg) d_st = STAT_NOT_FOUND;
                else if (c_reg.free) d_st = STAT_BAD_ARGUMENT;
                else begin
                    d_f = 1'b1;
                    d_s = pa ? p_reg.start : c_reg.start;
                    d_z = c_reg.size + (pa ? p_reg.size : 32'd0) + (na ? n_reg.size : 32'd0);
                    if (pa) begin
                        d_prim[0] = mk_ctl(CMD_WRITE, g_eff - 1'b1, d_s, d_z, 1'b1);
                        d_prim[1] = mk_ctl(CMD_REMOVE, g_eff, d_s, d_z, 1'b1);
                        d_prim[2] = mk_ctl(CMD_REMOVE, g_eff, d_s, d_z, 1'b1);
                        d_n = na ? 2'd3 : 2'd2;
                    end else begin
                        d_prim[0] = mk_ctl(CMD_WRITE, g_eff, d_s, d_z, 1'b1);
                        d_prim[1] = mk_ctl(CMD_REMOVE, g_eff + 1'b1, d_s, d_z, 1'b1);
                        d_n = na ? 2'd2 : 2'd1;
                    end
                end
            end
            OP_FIND: begin
                if (!last_ok_reg || (addr_reg - c_reg.start) >= c_reg.size)
                    d_st = STAT_NOT_FOUND;
                else begin
                    d_s = c_reg.start;
                    d_z = c_reg.size;
                    d_f = c_reg.free;
                end
            end
            OP_ALLOC_AT: begin
                sa = addr_reg;
                if (len_reg == 32'd0) d_st = STAT_BAD_ARGUMENT;
                else if (!last_ok_reg || (addr_reg - c_reg.start) >= c_reg.size)
                    d_st = STAT_OUT_OF_BOUNDS;
                else if (!c_reg.free) d_st = STAT_IN_USE;
                else if (c_reg.size - (addr_reg - c_reg.start) < len_reg)
                    d_st = STAT_TOO_BIG;
                else split = 1'b1;
            end
            OP_ALLOC_LOW, OP_ALLOC_HIGH, OP_ALLOC_BEST: begin
                if (len_reg == 32'd0) d_st = STAT_BAD_ARGUMENT;
                else if (!found_reg) d_st = STAT_OUT_OF_MEMORY;
                else split = 1'b1;
            end
            default: d_st = STAT_BAD_ARGUMENT;
        endcase
        if (split) begin
            off = sa - c_reg.start;
            pre = off != 32'd0;
            post = ({1'b0, off} + {1'b0, len_reg}) < {1'b0, c_reg.size};
            need = {1'b0, pre} + {1'b0, post};
            gb = g_eff + {{(IW-1){1'b0}}, pre};
            if (({1'b0, cnt_reg} + (IW+1)'(need)) > (IW+1)'(MAX_SEGMENTS))
                d_st = STAT_OUT_OF_RESOURCES;
            else begin
                d_s = sa;
                d_z = len_reg;
                d_prim[0] = mk_ctl(CMD_INSERT, g_eff, c_reg.start, off, 1'b1);
                d_prim[1] = mk_ctl(CMD_WRITE, gb, sa, len_reg, 1'b0);
                d_prim[2] = mk_ctl(CMD_INSERT, gb + 1'b1, sa + len_reg,
                                   c_reg.size - off - len_reg, 1'b1);
                if (!pre) begin
                    d_prim[0] = d_prim[1];
                    d_prim[1] = d_prim[2];
                end
                d_n = 2'd1 + need;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_DONE) m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg <= s_opcode;
                        addr_reg <= s_address;
                        len_reg <= s_length;
                        al_reg <= (s_alignment == 32'd0) ? 32'd1 : s_alignment;
                        k_reg <= '0;
                        found_reg <= 1'b0;
                        last_ok_reg <= 1'b0;
                        p_ok_reg <= 1'b0;
                        c_ok_reg <= 1'b0;
                        n_ok_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN, S_DIVW: begin
                    if (cand) state_reg <= S_DIVW;
                    if (advance) begin
                        if (hv && head.start <= addr_reg) begin
                            last_reg <= IW'(k_reg);
                            last_ok_reg <= 1'b1;
                        end
                        if (op_reg == OP_FREE && hv && head.start == addr_reg && !found_reg) begin
                            found_reg <= 1'b1;
                            g_reg <= IW'(k_reg);
                        end
                        if (state_reg == S_DIVW && take) begin
                            found_reg <= 1'b1;
                            g_reg <= IW'(k_reg);
                            a_reg <= fit_a;
                            bz_reg <= head.size;
                        end
                        k_reg <= k_last ? '0 : k_reg + 1'b1;
                        state_reg <= k_last ? S_GATHER : S_SCAN;
                    end
                end
                S_GATHER: begin
                    if (kk + 1'b1 == ge) begin
                        p_reg <= head;
                        p_ok_reg <= hv;
                    end
                    if (kk == ge) begin
                        c_reg <= head;
                        c_ok_reg <= hv;
                    end
                    if (kk == ge + 1'b1) begin
                        n_reg <= head;
                        n_ok_reg <= hv;
                    end
                    k_reg <= k_last ? '0 : k_reg + 1'b1;
                    if (k_last) state_reg <= S_DECIDE;
                end
                S_DECIDE: begin
                    res_st_reg <= d_st;
                    res_s_reg <= d_s;
                    res_z_reg <= d_z;
                    res_f_reg <= d_f;
                    for (int j = 0; j < 3; j++) prim_reg[j] <= d_prim[j];
                    nprim_reg <= d_n;
                    pi_reg <= '0;
                    state_reg <= (d_n == 2'd0) ? S_DONE : S_MODIFY;
                end
                S_MODIFY: begin
                    if (ctl.cmd == CMD_INSERT) cnt_reg <= cnt_reg + 1'b1;
                    else if (ctl.cmd == CMD_REMOVE) cnt_reg <= cnt_reg - 1'b1;
                    pi_reg <= pi_reg + 1'b1;
                    if (pi_reg == nprim_reg - 1'b1) state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_status_reg <= res_st_reg;
                        m_start_reg <= res_s_reg;
                        m_size_reg <= res_z_reg;
                        m_free_reg <= res_f_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_seg_start = m_start_reg;
    assign m_seg_size = m_size_reg;
    assign m_seg_free = m_free_reg;

endmodule

### rtl/core/ara_cell.sv
// One table cell: holds a segment and shifts, rotates or loads it.
`timescale 1ns / 1ps
module ara_cell import ara_pkg::*; (
    input  logic          aclk,
    input  logic [IW-1:0] cell_idx,
    input  cell_ctl_t     ctl,
    input  seg_t          left_seg,
    input  seg_t          right_seg,
    output seg_t          q
);

    seg_t q_reg;

    always_ff @(posedge aclk) begin
        case (ctl.cmd)
            CMD_ROT: q_reg <= right_seg;
            CMD_WRITE: begin
                if (ctl.idx == cell_idx) q_reg <= ctl.data;
            end
            CMD_INSERT: begin
                if (cell_idx > ctl.idx) q_reg <= left_seg;
                else if (cell_idx == ctl.idx) q_reg <= ctl.data;
            end
            CMD_REMOVE: begin
                if (cell_idx >= ctl.idx) q_reg <= right_seg;
            end
            default: ;
        endcase
    end

    assign q = q_reg;

endmodule

### rtl/core/ara_div.sv
// Restoring divider, one quotient bit per cycle, remainder output.
`timescale 1ns / 1ps
module ara_div import ara_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [32:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] rem
);

    logic [32:0]   rem_reg;
    logic [32:0]   dvd_reg;
    logic [31:0]   dsr_reg;
    logic [DW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;
    logic [32:0]   trial;

    assign trial = {rem_reg[31:0], dvd_reg[32]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
                rem_reg <= '0;
                dvd_reg <= dividend;
                dsr_reg <= divisor;
            end else if (run_reg) begin
                rem_reg <= (trial >= {1'b0, dsr_reg}) ? trial - {1'b0, dsr_reg} : trial;
                dvd_reg <= {dvd_reg[31:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DW'(DIV_STEPS - 1)) begin
                    run_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign rem = rem_reg[31:0];

endmodule

### rtl/core/ara_checker.sv
// Port-level checker for the allocator top level, with its bind.
`timescale 1ns / 1ps
module ara_checker import ara_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [2:0]  s_opcode,
    input logic [31:0] s_address,
    input logic [31:0] s_length,
    input logic [31:0] s_alignment,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [31:0] m_seg_start,
    input logic [31:0] m_seg_size,
    input logic        m_seg_free
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_seg_start))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STAT_OK |-> m_seg_start == 32'd0 && m_seg_size == 32'd0
            && !m_seg_free)
        else $error("error result carries segment data");

    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction taken while busy");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("bad state after reset");

endmodule

bind address_range_allocator_top ara_checker u_ara_checker (.*);

### tb/sv/address_range_allocator_top_tb.sv
// Testbench for the address range allocator: table-level predictor, scoreboard, directed and random traffic.
`timescale 1ns / 1ps
module address_range_allocator_top_tb;
    import ara_pkg::*;

    localparam logic [2:0] OP_UNDEFINED = 3'd7;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] start;
        logic [31:0] size;
        logic        free;
    } seg_result_t;

    class seg_scoreboard;
        logic [31:0] tab_start[$];
        logic [31:0] tab_size[$];
        bit          tab_free[$];
        seg_result_t pending[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        function int containing(logic [31:0] a);
            int last;
            last = -1;
            foreach (tab_start[k]) if (tab_start[k] <= a) last = k;
            if (last < 0) return -1;
            if (a - tab_start[last] >= tab_size[last]) return -1;
            return last;
        endfunction

        function int merge_into_free(int i);
            bit prev_adj, next_adj;
            prev_adj = (i > 0) && (tab_start[i-1] + tab_size[i-1] == tab_start[i]);
            next_adj = (i + 1 < tab_start.size()) &&
                       (tab_start[i] + tab_size[i] == tab_start[i+1]);
            tab_free[i] = 1;
            if (next_adj && tab_free[i+1]) begin
                tab_size[i] += tab_size[i+1];
                tab_start.delete(i+1); tab_size.delete(i+1); tab_free.delete(i+1);
            end
            if (prev_adj && tab_free[i-1]) begin
                tab_size[i-1] += tab_size[i];
                tab_start.delete(i); tab_size.delete(i); tab_free.delete(i);
                i--;
            end
            return i;
        endfunction

        function bit lowest_fit(int i, logic [31:0] n, logic [31:0] al, output logic [31:0] a);
            logic [63:0] s, c;
            a = 0;
            if (!tab_free[i] || tab_size[i] < n) return 0;
            s = tab_start[i];
            c = ((s + al - 1) / al) * al;
            if (c + n > s + tab_size[i]) return 0;
            a = c[31:0];
            return 1;
        endfunction

        function logic [2:0] carve(int i, logic [31:0] a, logic [31:0] n);
            logic [31:0] s, z, off;
            bit pre, post;
            s = tab_start[i]; z = tab_size[i]; off = a - s;
            pre = off > 0;
            post = ({32'd0, off} + n) < z;
            if (tab_start.size() + pre + post > MAX_SEGMENTS) return STAT_OUT_OF_RESOURCES;
            if (pre) begin
                tab_start.insert(i, s); tab_size.insert(i, off); tab_free.insert(i, 1);
                i++;
            end
            tab_start[i] = a; tab_size[i] = n; tab_free[i] = 0;
            if (post) begin
                tab_start.insert(i+1, a + n); tab_size.insert(i+1, z - off - n);
                tab_free.insert(i+1, 1);
            end
            return STAT_OK;
        endfunction

        function void note_request(logic [2:0] op, logic [31:0] addr, logic [31:0] len,
                                   logic [31:0] al_in);
            seg_result_t r;
            logic [31:0] al, a, c32, endv;
            logic [63:0] c;
            int idx, pos, best;
            bit found;
            r = '{STAT_OK, 0, 0, 0};
            al = (al_in == 0) ? 1 : al_in;
            found = 0; best = 0; a = 0;
            case (op)
                OP_ADD_FREE: begin
                    endv = addr + len;
                    if (len == 0 || (endv < addr && endv != 0)) r.status = STAT_BAD_ARGUMENT;
                    else if (containing(addr) >= 0) r.status = STAT_IN_USE;
                    else begin
                        pos = 0;
                        while (pos < tab_start.size() && tab_start[pos] < addr) pos++;
                        if (pos < tab_start.size() && (tab_start[pos] - addr) < len)
                            r.status = STAT_TOO_BIG;
                        else if (tab_start.size() >= MAX_SEGMENTS)
                            r.status = STAT_OUT_OF_RESOURCES;
                        else begin
                            tab_start.insert(pos, addr); tab_size.insert(pos, len);
                            tab_free.insert(pos, 0);
                            pos = merge_into_free(pos);
                            r.start = tab_start[pos]; r.size = tab_size[pos]; r.free = 1;
                        end
                    end
                end
                OP_ALLOC_AT: begin
                    if (len == 0) r.status = STAT_BAD_ARGUMENT;
                    else begin
                        idx = containing(addr);
                        if (idx < 0) r.status = STAT_OUT_OF_BOUNDS;
                        else if (!tab_free[idx]) r.status = STAT_IN_USE;
                        else if (tab_size[idx] - (addr - tab_start[idx]) < len)
                            r.status = STAT_TOO_BIG;
                        else begin
                            r.status = carve(idx, addr, len);
                            r.start = addr; r.size = len;
                        end
                    end
                end
                OP_ALLOC_LOW, OP_ALLOC_HIGH, OP_ALLOC_BEST: begin
                    if (len == 0) r.status = STAT_BAD_ARGUMENT;
                    else begin
                        if (op == OP_ALLOC_LOW) begin
                            for (int k = 0; k < tab_start.size() && !found; k++)
                                if (lowest_fit(k, len, al, a)) begin best = k; found = 1; end
                        end else if (op == OP_ALLOC_HIGH) begin
                            for (int k = tab_start.size() - 1; k >= 0 && !found; k--) begin
                                if (tab_free[k] && tab_size[k] >= len) begin
                                    c = (({32'd0, tab_start[k]} + tab_size[k] - len) / al) * al;
                                    if (c >= tab_start[k]) begin
                                        a = c[31:0]; best = k; found = 1;
                                    end
                                end
                            end
                        end else begin
                            foreach (tab_start[k])
                                if (lowest_fit(k, len, al, c32) &&
                                    (!found || tab_size[k] < tab_size[best])) begin
                                    best = k; a = c32; found = 1;
                                end
                        end
                        if (!found) r.status = STAT_OUT_OF_MEMORY;
                        else begin
                            r.status = carve(best, a, len);
                            r.start = a; r.size = len;
                        end
                    end
                end
                OP_FREE: begin
                    foreach (tab_start[k])
                        if (!found && tab_start[k] == addr) begin found = 1; idx = k; end
                    if (!found) r.status = STAT_NOT_FOUND;
                    else if (tab_free[idx]) r.status = STAT_BAD_ARGUMENT;
                    else begin
                        idx = merge_into_free(idx);
                        r.start = tab_start[idx]; r.size = tab_size[idx]; r.free = 1;
                    end
                end
                OP_FIND: begin
                    idx = containing(addr);
                    if (idx < 0) r.status = STAT_NOT_FOUND;
                    else begin
                        r.start = tab_start[idx]; r.size = tab_size[idx]; r.free = tab_free[idx];
                    end
                end
                default: r.status = STAT_BAD_ARGUMENT;
            endcase
            if (r.status != STAT_OK) r = '{r.status, 0, 0, 0};
            pending.push_back(r);
        endfunction

        function void report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endfunction

        function void check_result(logic [2:0] st, logic [31:0] s, logic [31:0] z, logic f);
            seg_result_t e;
            if (pending.size() == 0) begin
                report("result with no transaction outstanding");
                return;
            end
            e = pending.pop_front();
            if (st !== e.status) report($sformatf("status %0d exp %0d", st, e.status));
            if (s !== e.start) report($sformatf("seg_start %h exp %h", s, e.start));
            if (z !== e.size) report($sformatf("seg_size %h exp %h", z, e.size));
            if (f !== e.free) report($sformatf("seg_free %b exp %b", f, e.free));
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [2:0]  s_opcode = 0;
    logic [31:0] s_address = 0;
    logic [31:0] s_length = 0;
    logic [31:0] s_alignment = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [2:0]  m_status;
    logic [31:0] m_seg_start;
    logic [31:0] m_seg_size;
    logic        m_seg_free;

    seg_scoreboard sb = new();
    int  cycles = 0;
    bit  hold_off = 0;
    bit  sink_quiet = 0;
    localparam int LIMIT = 10000000;

    always #6 aclk = ~aclk;

    address_range_allocator_top u_top (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_status, m_seg_start, m_seg_size, m_seg_free);
        if (aresetn && s_valid && s_ready)
            sb.note_request(s_opcode, s_address, s_length, s_alignment);
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 300);
    endfunction

    // result side: random stalls, long hold-off on request
    initial begin
        int g;
        forever begin
            @(posedge aclk);
            if (hold_off) m_ready <= 0;
            else if (sink_quiet) m_ready <= 1;
            else begin
                g = gap_len();
                if (g == 0) m_ready <= 1;
                else begin
                    m_ready <= 0;
                    repeat (g - 1) @(posedge aclk);
                    m_ready <= 1;
                end
            end
        end
    end

    task automatic send(logic [2:0] op, logic [31:0] addr, logic [31:0] len,
                        logic [31:0] al, bit no_gap = 0);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            s_valid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1; s_opcode <= op; s_address <= addr; s_length <= len; s_alignment <= al;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_addr();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50 && sb.tab_start.size() > 0) begin
            int k;
            k = $urandom_range(0, sb.tab_start.size() - 1);
            return sb.tab_start[k] + ((p < 25) ? 0 : $urandom_range(0, 70));
        end
        if (p < 90) return $urandom_range(0, 16'hffff);
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 75) return $urandom_range(1, 300);
        if (p < 85) return $urandom_range(0, 3);
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_align();
        int p;
        p = $urandom_range(0, 99);
        if (p < 30) return 0;
        if (p < 80) return 32'd1 << $urandom_range(0, 6);
        if (p < 95) return $urandom_range(1, 100);
        return $urandom();
    endfunction

    initial begin
        logic [2:0] op;
        int p;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed
        send(OP_FIND, 0, 0, 0);
        send(OP_FREE, 100, 0, 0);
        send(OP_ALLOC_LOW, 0, 16, 0);
        send(OP_ADD_FREE, 32'h1000, 0, 0);
        send(OP_ADD_FREE, 32'hffff_ff00, 32'h200, 0);
        send(OP_ADD_FREE, 32'hffff_ff00, 32'h100, 0);
        send(OP_ADD_FREE, 32'h1000, 32'h1000, 0);
        send(OP_ADD_FREE, 32'h1800, 32'h10, 0);
        send(OP_ADD_FREE, 32'h0f00, 32'h200, 0);
        send(OP_ADD_FREE, 32'h0f00, 32'h100, 0);
        send(OP_ALLOC_AT, 32'h5000, 8, 0);
        send(OP_ALLOC_AT, 32'h1100, 32'h10, 0);
        send(OP_ALLOC_AT, 32'h1105, 4, 0);
        send(OP_ALLOC_AT, 32'h1f00, 32'h200, 0);
        send(OP_ALLOC_LOW, 0, 32'h30, 32'h40);
        send(OP_ALLOC_HIGH, 0, 32'h30, 32'h40);
        send(OP_ALLOC_BEST, 0, 32'h20, 0);
        send(OP_ALLOC_BEST, 0, 32'hffff_ffff, 32'hffff_ffff);
        send(OP_ALLOC_HIGH, 0, 32'h10, 32'hffff_ffff);
        send(OP_FIND, 32'h1101, 0, 0);
        send(OP_FREE, 32'h1100, 0, 0);
        send(OP_FREE, 32'h1000, 0, 0);
        send(OP_FREE, 32'h0f00, 0, 0);
        send(OP_UNDEFINED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        drain();

        // fill the table with fragments to reach out_of_resources
        sink_quiet = 1;
        send(OP_ADD_FREE, 32'h2000_0000, 32'h1000, 0, 1);
        for (int i = 0; i < 40; i++)
            send(OP_ALLOC_AT, 32'h2000_0000 + i * 32'h40 + 8, 4, 0, 1);
        send(OP_ADD_FREE, 32'h3000_0000, 32'h10, 0, 1);
        send(OP_ALLOC_LOW, 0, 1, 0, 1);
        for (int i = 0; i < 40; i++)
            send(OP_FREE, 32'h2000_0000 + i * 32'h40 + 8, 0, 0, 1);
        sink_quiet = 0;

        // receiver holds off while the sender keeps going
        fork
            begin
                hold_off = 1;
                repeat (2000) @(posedge aclk);
                hold_off = 0;
            end
            for (int i = 0; i < 6; i++) send(OP_FIND, pick_addr(), 0, 0, 1);
        join
        drain();

        for (int n = 0; n < 640; n++) begin
            p = $urandom_range(0, 99);
            if (p < 15) op = OP_ADD_FREE;
            else if (p < 27) op = OP_ALLOC_AT;
            else if (p < 42) op = OP_ALLOC_LOW;
            else if (p < 55) op = OP_ALLOC_HIGH;
            else if (p < 68) op = OP_ALLOC_BEST;
            else if (p < 85) op = OP_FREE;
            else if (p < 97) op = OP_FIND;
            else op = OP_UNDEFINED;
            send(op, pick_addr(), pick_len(), pick_align(), $urandom_range(0, 3) == 0);
            if (n == 320) drain();
        end

        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule

### sim.f
rtl/core/ara_pkg.sv
rtl/core/ara_cell.sv
rtl/core/ara_div.sv
rtl/core/address_range_allocator_top.sv
rtl/core/ara_checker.sv
tb/sv/address_range_allocator_top_tb.sv
